// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cell engine
// Field widths, character codes, register indexes, microcode word layout
// and the control program that the sequencer steps through.
// ---------------------------------------------------------------------------
package tcce_pkg;

  // Default store geometry
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  // Port field widths
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 13;
  localparam int SCROLL_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_COL_W  = 8;
  localparam int CFG_ROW_W  = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // Register reset values
  localparam logic [CFG_COL_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [CFG_ROW_W-1:0] ROWS_RESET    = 7'd25;
  localparam logic [CHAR_W-1:0]    ATTR_RESET    = 8'h0F;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_IDLE,
    OP_GEOM,
    OP_USED,
    OP_PRE,
    OP_POST,
    OP_PUTCH,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEWLINE,
    OP_BACK,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_WR,
    OP_BL_INIT,
    OP_BL_WR,
    OP_SC_END,
    OP_CL_INIT,
    OP_CL_WR,
    OP_RD_ISSUE,
    OP_RD_TAKE,
    OP_FINISH
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NSTART,
    C_READ,
    C_PUT,
    C_CLEAR,
    C_CUR_LT_TOT,
    C_NEWLINE,
    C_BACKSPACE,
    C_CUR_ZERO,
    C_DIV_MORE,
    C_USED_ZERO,
    C_SC_MORE,
    C_BL_MORE,
    C_CL_MORE,
    C_PRE
  } cond_t;

  typedef logic [4:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucw_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic is_read;
    logic put_go;
    logic clear_go;
    logic cur_lt_tot;
    logic newline;
    logic backspace;
    logic cur_zero;
    logic div_more;
    logic used_zero;
    logic sc_more;
    logic bl_more;
    logic cl_more;
    logic pre;
  } tcce_flags_t;

  // Program addresses
  localparam step_t ST_IDLE  = 5'd0;
  localparam step_t ST_DISP0 = 5'd1;
  localparam step_t ST_DISP1 = 5'd2;
  localparam step_t ST_DISP2 = 5'd3;
  localparam step_t ST_DISP3 = 5'd4;
  localparam step_t ST_P0    = 5'd5;
  localparam step_t ST_P1    = 5'd6;
  localparam step_t ST_PCH0  = 5'd7;
  localparam step_t ST_PCH1  = 5'd8;
  localparam step_t ST_PCH2  = 5'd9;
  localparam step_t ST_NL0   = 5'd10;
  localparam step_t ST_NL1   = 5'd11;
  localparam step_t ST_NL2   = 5'd12;
  localparam step_t ST_BS0   = 5'd13;
  localparam step_t ST_BS1   = 5'd14;
  localparam step_t ST_PP0   = 5'd15;
  localparam step_t ST_PP1   = 5'd16;
  localparam step_t ST_SC0   = 5'd17;
  localparam step_t ST_SC1   = 5'd18;
  localparam step_t ST_SC2   = 5'd19;
  localparam step_t ST_SC3   = 5'd20;
  localparam step_t ST_SC4   = 5'd21;
  localparam step_t ST_SC5   = 5'd22;
  localparam step_t ST_FIN   = 5'd23;
  localparam step_t ST_CL0   = 5'd24;
  localparam step_t ST_CL1   = 5'd25;
  localparam step_t ST_CL2   = 5'd26;
  localparam step_t ST_RD0   = 5'd27;
  localparam step_t ST_RD1   = 5'd28;
  localparam step_t ST_RST0  = 5'd29;
  localparam step_t ST_RST1  = 5'd30;
  localparam step_t ST_RST2  = 5'd31;

  // Control store: one word per step; jump to target when cond holds
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: ST_IDLE};
    case (s)
      ST_IDLE:  w = '{op: OP_IDLE,     cond: C_NSTART,     target: ST_IDLE};
      ST_DISP0: w = '{op: OP_GEOM,     cond: C_READ,       target: ST_RD0};
      ST_DISP1: w = '{op: OP_USED,     cond: C_PUT,        target: ST_P0};
      ST_DISP2: w = '{op: OP_NOP,      cond: C_CLEAR,      target: ST_CL0};
      ST_DISP3: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_FIN};
      ST_P0:    w = '{op: OP_NOP,      cond: C_CUR_LT_TOT, target: ST_PCH0};
      ST_P1:    w = '{op: OP_PRE,      cond: C_ALWAYS,     target: ST_SC0};
      ST_PCH0:  w = '{op: OP_NOP,      cond: C_NEWLINE,    target: ST_NL0};
      ST_PCH1:  w = '{op: OP_NOP,      cond: C_BACKSPACE,  target: ST_BS0};
      ST_PCH2:  w = '{op: OP_PUTCH,    cond: C_ALWAYS,     target: ST_PP0};
      ST_NL0:   w = '{op: OP_DIV_INIT, cond: C_NEVER,      target: ST_IDLE};
      ST_NL1:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,   target: ST_NL1};
      ST_NL2:   w = '{op: OP_NEWLINE,  cond: C_ALWAYS,     target: ST_PP0};
      ST_BS0:   w = '{op: OP_NOP,      cond: C_CUR_ZERO,   target: ST_PP0};
      ST_BS1:   w = '{op: OP_BACK,     cond: C_ALWAYS,     target: ST_PP0};
      ST_PP0:   w = '{op: OP_NOP,      cond: C_CUR_LT_TOT, target: ST_FIN};
      ST_PP1:   w = '{op: OP_POST,     cond: C_ALWAYS,     target: ST_SC0};
      ST_SC0:   w = '{op: OP_SC_INIT,  cond: C_USED_ZERO,  target: ST_SC3};
      ST_SC1:   w = '{op: OP_SC_RD,    cond: C_NEVER,      target: ST_IDLE};
      ST_SC2:   w = '{op: OP_SC_WR,    cond: C_SC_MORE,    target: ST_SC1};
      ST_SC3:   w = '{op: OP_BL_INIT,  cond: C_NEVER,      target: ST_IDLE};
      ST_SC4:   w = '{op: OP_BL_WR,    cond: C_BL_MORE,    target: ST_SC4};
      ST_SC5:   w = '{op: OP_SC_END,   cond: C_PRE,        target: ST_PCH0};
      ST_FIN:   w = '{op: OP_FINISH,   cond: C_ALWAYS,     target: ST_IDLE};
      ST_CL0:   w = '{op: OP_CL_INIT,  cond: C_NEVER,      target: ST_IDLE};
      ST_CL1:   w = '{op: OP_CL_WR,    cond: C_CL_MORE,    target: ST_CL1};
      ST_CL2:   w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_FIN};
      ST_RD0:   w = '{op: OP_RD_ISSUE, cond: C_NEVER,      target: ST_IDLE};
      ST_RD1:   w = '{op: OP_RD_TAKE,  cond: C_ALWAYS,     target: ST_FIN};
      ST_RST0:  w = '{op: OP_CL_INIT,  cond: C_NEVER,      target: ST_IDLE};
      ST_RST1:  w = '{op: OP_CL_WR,    cond: C_CL_MORE,    target: ST_RST1};
      ST_RST2:  w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_IDLE};
      default:  w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/tcce_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcce_seq: microcode sequencer
// Holds the step counter, fetches the control word and resolves the
// conditional jump from the datapath flags.
// ---------------------------------------------------------------------------
module tcce_seq
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  tcce_flags_t flags,
  output ucw_t        ucw,
  output logic        busy
);

  step_t step_r;
  step_t step_nxt;
  logic  take_jump;

  // Fetch the current control word
  assign ucw  = ucode(step_r);
  assign busy = (step_r != ST_IDLE);

  // Resolve the jump condition
  always_comb begin
    case (ucw.cond)
      C_NEVER:      take_jump = 1'b0;
      C_ALWAYS:     take_jump = 1'b1;
      C_NSTART:     take_jump = !start;
      C_READ:       take_jump = flags.is_read;
      C_PUT:        take_jump = flags.put_go;
      C_CLEAR:      take_jump = flags.clear_go;
      C_CUR_LT_TOT: take_jump = flags.cur_lt_tot;
      C_NEWLINE:    take_jump = flags.newline;
      C_BACKSPACE:  take_jump = flags.backspace;
      C_CUR_ZERO:   take_jump = flags.cur_zero;
      C_DIV_MORE:   take_jump = flags.div_more;
      C_USED_ZERO:  take_jump = flags.used_zero;
      C_SC_MORE:    take_jump = flags.sc_more;
      C_BL_MORE:    take_jump = flags.bl_more;
      C_CL_MORE:    take_jump = flags.cl_more;
      C_PRE:        take_jump = flags.pre;
      default:      take_jump = 1'b0;
    endcase
  end

  assign step_nxt = take_jump ? ucw.target : step_r + 5'd1;

  // Advance the step counter; reset enters the store clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_RST0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/text_console_cell_engine_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_cell_engine_core: character-cell text console
// Cursor, character store, put/clear/read transactions with scrolling.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears on the out_ ports for exactly one cycle under out_strobe and must
// be captured then, as the receiver cannot stall. One transaction is worked
// at a time by a microcoded sequencer over a single-write, single-read store
// memory. A newline works out a bit-serial remainder of the cursor over
// the column count, and each scroll moves the visible screen up one row,
// reading each cell and then writing it a row higher, and blanks the bottom
// row. A clear item, and the pass after reset, write every cell of the
// store one per cycle; busy stays high meanwhile while configuration
// writes are taken.
// ---------------------------------------------------------------------------
module text_console_cell_engine_core
  import tcce_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [CELL_W-1:0]     in_cell_index,
  // Result channel
  output logic                  out_strobe,
  output logic [CELL_W-1:0]     out_cursor_pos,
  output logic                  out_did_write,
  output logic [CELL_W-1:0]     out_write_cell,
  output logic [CHAR_W-1:0]     out_write_char,
  output logic [CHAR_W-1:0]     out_write_attr,
  output logic [SCROLL_W-1:0]   out_scroll_count,
  output logic [CHAR_W-1:0]     out_read_char
);

  localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
  localparam int CUR_W = $clog2(STORE_CELLS) + 1;
  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int CNT_W = $clog2(CUR_W + 1);

  // Configuration registers
  logic [CFG_COL_W-1:0] cols_cfg_r;
  logic [CFG_ROW_W-1:0] rows_cfg_r;
  logic [CHAR_W-1:0]    attr_cfg_r;
  logic                 en_cfg_r;

  // Item and datapath registers
  logic [CUR_W-1:0]    cursor_r, cursor_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [CELL_W-1:0]   idx_r, idx_nxt;
  logic [CUR_W-1:0]    total_r, total_nxt;
  logic [CUR_W-1:0]    used_r, used_nxt;
  logic [CUR_W-1:0]    ptr_r, ptr_nxt;
  logic [COL_W-1:0]    rem_r, rem_nxt;
  logic [CUR_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic                post_r, post_nxt;
  logic                did_r, did_nxt;
  logic [CUR_W-1:0]    wcell_r, wcell_nxt;
  logic [CHAR_W-1:0]   wchar_r, wchar_nxt;
  logic [CHAR_W-1:0]   wattr_r, wattr_nxt;
  logic [SCROLL_W-1:0] scrolls_r, scrolls_nxt;
  logic [CHAR_W-1:0]   rchar_r, rchar_nxt;
  logic                strobe_r, strobe_nxt;

  // Store memory ports
  logic [CHAR_W-1:0] store_mem [STORE_CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] rd_data_r;

  // Effective geometry and helpers
  logic [COL_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic [CUR_W-1:0]  ptr_inc;
  logic [COL_W:0]    div_trial;
  logic              idx_in_range;
  ucw_t              ucw;
  tcce_flags_t       flags;

  // Clamp the programmed geometry into the store
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_eff = COL_W'(1);
    end else if ({1'b0, cols_cfg_r} > 9'(MAX_COLUMNS)) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COL_W'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if ({1'b0, rows_cfg_r} > 8'(MAX_ROWS)) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_W'(rows_cfg_r);
    end
  end

  assign ptr_inc      = ptr_r + CUR_W'(1);
  assign div_trial    = {rem_r, dvd_r[CUR_W-1]};
  assign idx_in_range = (32'(idx_r) < 32'(STORE_CELLS));

  // Status for the sequencer
  always_comb begin
    flags.is_read    = (req_r == REQ_READ);
    flags.put_go     = (req_r == REQ_PUT) && en_cfg_r;
    flags.clear_go   = (req_r == REQ_CLEAR) && en_cfg_r;
    flags.cur_lt_tot = (cursor_r < total_r);
    flags.newline    = (char_r == CH_NEWLINE);
    flags.backspace  = (char_r == CH_BACKSPACE);
    flags.cur_zero   = (cursor_r == '0);
    flags.div_more   = (dcnt_r != CNT_W'(1));
    flags.used_zero  = (used_r == '0);
    flags.sc_more    = (ptr_inc < used_r);
    flags.bl_more    = (ptr_inc < total_r);
    flags.cl_more    = (ptr_inc < CUR_W'(STORE_CELLS));
    flags.pre        = !post_r;
  end

  tcce_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ucw   (ucw),
    .busy  (busy)
  );

  // Datapath: carry out the micro-operation of the current step
  always_comb begin
    cursor_nxt  = cursor_r;
    req_nxt     = req_r;
    char_nxt    = char_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    used_nxt    = used_r;
    ptr_nxt     = ptr_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    dcnt_nxt    = dcnt_r;
    post_nxt    = post_r;
    did_nxt     = did_r;
    wcell_nxt   = wcell_r;
    wchar_nxt   = wchar_r;
    wattr_nxt   = wattr_r;
    scrolls_nxt = scrolls_r;
    rchar_nxt   = rchar_r;
    strobe_nxt  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(ptr_r);
    mem_wdata   = CH_SPACE;
    mem_raddr   = AW'(ptr_r + CUR_W'(cols_eff));
    case (ucw.op)
      OP_IDLE: begin
        // take a new transaction and clear its result
        if (start) begin
          req_nxt     = in_req_type;
          char_nxt    = in_char_code;
          idx_nxt     = in_cell_index;
          did_nxt     = 1'b0;
          wcell_nxt   = '0;
          wchar_nxt   = '0;
          wattr_nxt   = '0;
          scrolls_nxt = '0;
          rchar_nxt   = '0;
        end
      end
      OP_GEOM: begin
        total_nxt = CUR_W'(cols_eff) * CUR_W'(rows_eff);
      end
      OP_USED: begin
        used_nxt = total_r - CUR_W'(cols_eff);
      end
      OP_PRE: begin
        post_nxt = 1'b0;
      end
      OP_POST: begin
        post_nxt = 1'b1;
      end
      OP_PUTCH: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cursor_r);
        mem_wdata = char_r;
        did_nxt   = 1'b1;
        wcell_nxt = cursor_r;
        wchar_nxt = char_r;
        wattr_nxt = attr_cfg_r;
        cursor_nxt = cursor_r + CUR_W'(1);
      end
      OP_DIV_INIT: begin
        rem_nxt  = '0;
        dvd_nxt  = cursor_r;
        dcnt_nxt = CNT_W'(CUR_W);
      end
      OP_DIV_STEP: begin
        // one restoring remainder bit per cycle
        if (div_trial >= {1'b0, cols_eff}) begin
          rem_nxt = COL_W'(div_trial - {1'b0, cols_eff});
        end else begin
          rem_nxt = COL_W'(div_trial);
        end
        dvd_nxt  = {dvd_r[CUR_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r - CNT_W'(1);
      end
      OP_NEWLINE: begin
        cursor_nxt = cursor_r - CUR_W'(rem_r) + CUR_W'(cols_eff);
      end
      OP_BACK: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(cursor_r - CUR_W'(1));
        mem_wdata  = CH_SPACE;
        did_nxt    = 1'b1;
        wcell_nxt  = cursor_r - CUR_W'(1);
        wchar_nxt  = CH_SPACE;
        wattr_nxt  = attr_cfg_r;
        cursor_nxt = cursor_r - CUR_W'(1);
      end
      OP_SC_INIT: begin
        ptr_nxt     = '0;
        scrolls_nxt = scrolls_r + SCROLL_W'(1);
      end
      OP_SC_RD: begin
        mem_raddr = AW'(ptr_r + CUR_W'(cols_eff));
      end
      OP_SC_WR: begin
        // move one cell up a row
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r);
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_inc;
      end
      OP_BL_INIT: begin
        ptr_nxt = used_r;
      end
      OP_BL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r);
        mem_wdata = CH_SPACE;
        ptr_nxt   = ptr_inc;
      end
      OP_SC_END: begin
        cursor_nxt = used_r;
      end
      OP_CL_INIT: begin
        ptr_nxt    = '0;
        cursor_nxt = '0;
      end
      OP_CL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ptr_r);
        mem_wdata = CH_SPACE;
        ptr_nxt   = ptr_inc;
      end
      OP_RD_ISSUE: begin
        mem_raddr = AW'(idx_r);
      end
      OP_RD_TAKE: begin
        rchar_nxt = idx_in_range ? rd_data_r : CH_SPACE;
      end
      OP_FINISH: begin
        strobe_nxt = 1'b1;
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  // Store memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[mem_raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLUMNS_RESET;
      rows_cfg_r <= ROWS_RESET;
      attr_cfg_r <= ATTR_RESET;
      en_cfg_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cols_cfg_r <= cfg_wdata[CFG_COL_W-1:0];
        CFG_ROWS:    rows_cfg_r <= cfg_wdata[CFG_ROW_W-1:0];
        CFG_ATTR:    attr_cfg_r <= cfg_wdata[CHAR_W-1:0];
        CFG_ENABLE:  en_cfg_r   <= cfg_wdata[0];
        default:     en_cfg_r   <= en_cfg_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    char_r    <= char_nxt;
    idx_r     <= idx_nxt;
    total_r   <= total_nxt;
    used_r    <= used_nxt;
    ptr_r     <= ptr_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    dcnt_r    <= dcnt_nxt;
    post_r    <= post_nxt;
    did_r     <= did_nxt;
    wcell_r   <= wcell_nxt;
    wchar_r   <= wchar_nxt;
    wattr_r   <= wattr_nxt;
    scrolls_r <= scrolls_nxt;
    rchar_r   <= rchar_nxt;
  end

  // Result ports
  assign out_strobe       = strobe_r;
  assign out_cursor_pos   = CELL_W'(cursor_r);
  assign out_did_write    = did_r;
  assign out_write_cell   = CELL_W'(wcell_r);
  assign out_write_char   = wchar_r;
  assign out_write_attr   = wattr_r;
  assign out_scroll_count = scrolls_r;
  assign out_read_char    = rchar_r;

  // One result per transaction, never two strobes in a row
  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A taken transaction makes the block busy
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction taken but block not busy");

  // The result is shown only once the sequencer is back at rest
  a_strobe_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while work still in progress");

  // Write fields stay zero when no cell was written
  a_write_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_did_write) |->
      (out_write_char == '0 && out_write_attr == '0 && out_write_cell == '0))
    else $error("write fields set without a cell write");

endmodule

// ===== sim/tb_text_console_cell_engine_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_console_cell_engine_core: self-checking bench for the text console
// A directed run covers the disabled console, character edits, geometry
// clamping, shrinking geometry and double scrolls. Random phases follow,
// over many settings and sender idling levels. A transaction-level model
// of the cursor and character store predicts every result, and each strobed
// result is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_text_console_cell_engine_core;
  import tcce_pkg::*;

  localparam int MAX_COLS    = DEF_MAX_COLUMNS;
  localparam int MAX_LINES   = DEF_MAX_ROWS;
  localparam int STORE_CELLS = MAX_COLS * MAX_LINES;
  localparam int CELL_AW     = $clog2(STORE_CELLS);
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 32;

  // Request code that the block ignores
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0]   cursor_pos;
    logic                did_write;
    logic [CELL_W-1:0]   write_cell;
    logic [CHAR_W-1:0]   write_char;
    logic [CHAR_W-1:0]   write_attr;
    logic [SCROLL_W-1:0] scroll_count;
    logic [CHAR_W-1:0]   read_char;
  } cell_result_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      in_req_type   = REQ_PUT;
  logic [CHAR_W-1:0]     in_char_code  = '0;
  logic [CELL_W-1:0]     in_cell_index = '0;
  logic                  out_strobe;
  logic [CELL_W-1:0]     out_cursor_pos;
  logic                  out_did_write;
  logic [CELL_W-1:0]     out_write_cell;
  logic [CHAR_W-1:0]     out_write_char;
  logic [CHAR_W-1:0]     out_write_attr;
  logic [SCROLL_W-1:0]   out_scroll_count;
  logic [CHAR_W-1:0]     out_read_char;

  // Console model: settings, cursor and character store
  logic [CFG_COL_W-1:0]  set_columns;
  logic [CFG_ROW_W-1:0]  set_rows;
  logic [CHAR_W-1:0]     set_attr;
  logic                  set_enable;
  int                    console_cursor;
  logic [CHAR_W-1:0]     console_cells [STORE_CELLS];

  cell_result_t          pending_results [$];
  cell_result_t          oldest_result;
  int                    mismatch_count = 0;
  int                    result_count   = 0;
  int                    idle_pct       = 0;
  int                    cycle_count    = 0;

  text_console_cell_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .out_strobe       (out_strobe),
    .out_cursor_pos   (out_cursor_pos),
    .out_did_write    (out_did_write),
    .out_write_cell   (out_write_cell),
    .out_write_char   (out_write_char),
    .out_write_attr   (out_write_attr),
    .out_scroll_count (out_scroll_count),
    .out_read_char    (out_read_char)
  );

  // Free-running clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Geometry as the block sees it: zero counts as one, clamp at the maximum
  function automatic int active_columns();
    int c;
    c = int'(set_columns);
    if (c == 0) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int active_rows();
    int r;
    r = int'(set_rows);
    if (r == 0) r = 1;
    if (r > MAX_LINES) r = MAX_LINES;
    return r;
  endfunction

  task automatic blank_store();
    for (int i = 0; i < STORE_CELLS; i++) console_cells[CELL_AW'(i)] = CH_SPACE;
  endtask

  // Move the visible screen up one row and blank the bottom row
  task automatic scroll_screen(input int cols, input int rows);
    int used;
    used = cols * (rows - 1);
    for (int i = 0; i < used; i++)
      console_cells[CELL_AW'(i)] = console_cells[CELL_AW'(i + cols)];
    for (int i = 0; i < cols; i++) console_cells[CELL_AW'(used + i)] = CH_SPACE;
    console_cursor = used;
  endtask

  // Work out the result of one transaction and update the console model
  task automatic predict_console(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                 input logic [CELL_W-1:0] idx, output cell_result_t r);
    int cols;
    int rows;
    int total;
    r     = '0;
    cols  = active_columns();
    rows  = active_rows();
    total = cols * rows;
    if (req == REQ_PUT && set_enable) begin
      if (console_cursor >= total) begin
        scroll_screen(cols, rows);
        r.scroll_count = r.scroll_count + SCROLL_W'(1);
      end
      if (ch == CH_NEWLINE) begin
        console_cursor = (console_cursor / cols + 1) * cols;
      end else if (ch == CH_BACKSPACE) begin
        if (console_cursor > 0) begin
          console_cursor--;
          console_cells[CELL_AW'(console_cursor)] = CH_SPACE;
          r.did_write  = 1'b1;
          r.write_cell = console_cursor[CELL_W-1:0];
          r.write_char = CH_SPACE;
          r.write_attr = set_attr;
        end
      end else begin
        console_cells[CELL_AW'(console_cursor)] = ch;
        r.did_write  = 1'b1;
        r.write_cell = console_cursor[CELL_W-1:0];
        r.write_char = ch;
        r.write_attr = set_attr;
        console_cursor++;
      end
      if (console_cursor >= total) begin
        scroll_screen(cols, rows);
        r.scroll_count = r.scroll_count + SCROLL_W'(1);
      end
    end else if (req == REQ_CLEAR && set_enable) begin
      blank_store();
      console_cursor = 0;
    end else if (req == REQ_READ) begin
      r.read_char = (int'(idx) < STORE_CELLS) ? console_cells[idx] : CH_SPACE;
    end
    r.cursor_pos = console_cursor[CELL_W-1:0];
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] result %0d: %s is %0h, expected %0h", $time, result_count, field,
             got, want);
    mismatch_count++;
  endtask

  // Present one transaction, hold it until taken, then record its prediction
  task automatic send_command(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                              input logic [CELL_W-1:0] idx);
    cell_result_t r;
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    predict_console(req, ch, idx, r);
    pending_results.push_back(r);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_command(REQ_PUT, ch, '0);
  endtask

  task automatic read_cell(input int idx);
    send_command(REQ_READ, CHAR_W'($urandom_range(0, 255)), idx[CELL_W-1:0]);
  endtask

  // Drop start, let every result arrive and wait for the block to go idle
  task automatic wait_until_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Write all four registers back to back while the block is idle
  task automatic apply_settings(input int cols, input int rows, input int attr,
                                input int en);
    wait_until_idle();
    cfg_beat(CFG_COLUMNS, cols);
    cfg_beat(CFG_ROWS, rows);
    cfg_beat(CFG_ATTR, attr);
    cfg_beat(CFG_ENABLE, en);
    cfg_we      <= 1'b0;
    set_columns = cols[CFG_COL_W-1:0];
    set_rows    = rows[CFG_ROW_W-1:0];
    set_attr    = attr[CHAR_W-1:0];
    set_enable  = en[0];
  endtask

  // Reset settings, console disabled: only reads act
  task automatic test_disabled_console();
    put_char(8'h41);
    send_command(REQ_CLEAR, 8'h00, '0);
    read_cell(0);
    send_command(REQ_IGNORED, 8'hFF, '1);
  endtask

  // Characters at the extremes, backspace, newline and backspace at cell zero
  task automatic test_put_and_edit();
    apply_settings(80, 25, 8'hFF, 1);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    put_char(CH_BACKSPACE);
    read_cell(0);
    read_cell(2);
    send_command(REQ_CLEAR, 8'h55, '0);
    put_char(CH_BACKSPACE);
    read_cell(0);
  endtask

  // Zero geometry counts as one cell; oversize geometry clamps to the store
  task automatic test_geometry_limits();
    apply_settings(0, 0, 8'h00, 1);
    put_char(8'h5A);
    apply_settings(255, 127, 8'h80, 1);
    put_char(CH_NEWLINE);
    read_cell(STORE_CELLS - 1);
    send_command(REQ_IGNORED, 8'h00, 13'h0AAA);
  endtask

  // Shrink the screen under the cursor: scroll before the put, then twice
  task automatic test_geometry_shrink();
    apply_settings(10, 2, 8'h3C, 1);
    put_char(8'h78);
    apply_settings(1, 1, 8'hC3, 1);
    put_char(8'h79);
    read_cell(10);
    read_cell(0);
  endtask

  // Random transactions under the current settings
  task automatic run_random_phase(input int count, input int gap_pct,
                                  input bit allow_clear, input int newline_pct);
    int roll;
    int pick;
    int total;
    idle_pct = gap_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (allow_clear && roll < 2) begin
        send_command(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     CELL_W'($urandom_range(0, 8191)));
      end else if (roll < 14) begin
        total = active_columns() * active_rows();
        if ($urandom_range(0, 1) == 0) read_cell($urandom_range(0, total - 1));
        else read_cell($urandom_range(0, STORE_CELLS - 1));
      end else if (roll < 18) begin
        send_command(REQ_IGNORED, CHAR_W'($urandom_range(0, 255)),
                     CELL_W'($urandom_range(0, 8191)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < newline_pct) put_char(CH_NEWLINE);
        else if (pick < newline_pct + 10) put_char(CH_BACKSPACE);
        else put_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_console();
    apply_settings(8, 4, $urandom_range(0, 255), 1);
    run_random_phase(100, 0, 1'b1, 8);
    apply_settings(1, 1, 8'h00, 1);
    run_random_phase(60, 56, 1'b1, 8);
    // Full-size screen: newlines reach the bottom and force deep scrolls
    apply_settings(128, 64, 8'hFF, 1);
    run_random_phase(70, 16, 1'b0, 85);
    apply_settings($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(0, 255), 1);
    run_random_phase(120, 56, 1'b1, 10);
    apply_settings($urandom_range(200, 255), 1, $urandom_range(0, 255), 1);
    run_random_phase(60, 0, 1'b1, 10);
    apply_settings($urandom_range(1, 128), $urandom_range(1, 64), $urandom_range(0, 255), 0);
    run_random_phase(60, 16, 1'b1, 10);
    apply_settings(0, $urandom_range(65, 127), $urandom_range(0, 255), 1);
    run_random_phase(80, 56, 1'b1, 10);
    for (int p = 0; p < 4; p++) begin
      apply_settings($urandom_range(1, 20), $urandom_range(1, 10), $urandom_range(0, 255), 1);
      run_random_phase(100, (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 56 : 16), 1'b1, 10);
    end
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cursor_pos", 32'(out_cursor_pos), 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_cursor_pos !== oldest_result.cursor_pos)
          report_mismatch("cursor_pos", 32'(out_cursor_pos),
                          32'(oldest_result.cursor_pos));
        if (out_did_write !== oldest_result.did_write)
          report_mismatch("did_write", 32'(out_did_write), 32'(oldest_result.did_write));
        if (out_write_cell !== oldest_result.write_cell)
          report_mismatch("write_cell", 32'(out_write_cell),
                          32'(oldest_result.write_cell));
        if (out_write_char !== oldest_result.write_char)
          report_mismatch("write_char", 32'(out_write_char),
                          32'(oldest_result.write_char));
        if (out_write_attr !== oldest_result.write_attr)
          report_mismatch("write_attr", 32'(out_write_attr),
                          32'(oldest_result.write_attr));
        if (out_scroll_count !== oldest_result.scroll_count)
          report_mismatch("scroll_count", 32'(out_scroll_count),
                          32'(oldest_result.scroll_count));
        if (out_read_char !== oldest_result.read_char)
          report_mismatch("read_char", 32'(out_read_char), 32'(oldest_result.read_char));
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // Reset, then run the tests in turn
  initial begin
    set_columns    = COLUMNS_RESET;
    set_rows       = ROWS_RESET;
    set_attr       = ATTR_RESET;
    set_enable     = 1'b0;
    console_cursor = 0;
    blank_store();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_console();
    test_put_and_edit();
    test_geometry_limits();
    test_geometry_shrink();
    test_random_console();
    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
